FILE: hw/rtl/ctss_pkg.sv
// ----------------------------------------------------------------------------
// ctss_pkg
// Types, constants and helpers for the charge / UART time slot sequencer.
// ----------------------------------------------------------------------------
package ctss_pkg;

	typedef enum logic [2:0] {
		MODE_CHARGE   = 3'd0,
		MODE_PRE_RX   = 3'd1,
		MODE_RX       = 3'd2,
		MODE_TURN     = 3'd3,
		MODE_TX       = 3'd4,
		MODE_POST_TX  = 3'd5,
		MODE_RECOVER  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_HOST   = 2'd1,
		KIND_CABLE  = 2'd2
	} kind_t;

	// register indexes
	localparam logic [2:0] REG_CHARGE    = 3'd0;
	localparam logic [2:0] REG_PRE_RX    = 3'd1;
	localparam logic [2:0] REG_RX        = 3'd2;
	localparam logic [2:0] REG_TURN      = 3'd3;
	localparam logic [2:0] REG_TX        = 3'd4;
	localparam logic [2:0] REG_POST_TX   = 3'd5;
	localparam logic [2:0] REG_RECOVER   = 3'd6;

	localparam logic [15:0] CHARGE_TIME_RST    = 16'd200;
	localparam logic [15:0] PRE_RX_TIME_RST    = 16'd250;
	localparam logic [15:0] RX_TIME_RST        = 16'd430;
	localparam logic [15:0] TURN_TIME_RST      = 16'd1;
	localparam logic [15:0] TX_TIME_RST        = 16'd150;
	localparam logic [15:0] POST_TX_TIME_RST   = 16'd10;
	localparam logic [15:0] RECOVER_TIME_RST   = 16'd341;

	localparam int TX_DEPTH_DEF = 1024;
	localparam int RX_DEPTH_DEF = 1024;

	localparam logic [7:0] NULL_BYTE = 8'h00;

	// drive levels, {uart_enable, charge_led, charge_relay, rx_relay, tx_relay}
	typedef struct packed {
		logic uart_enable;
		logic charge_led;
		logic charge_relay;
		logic rx_relay;
		logic tx_relay;
	} levels_t;

	function automatic levels_t mode_levels(input mode_t m);
		levels_t l;
		l = '0;
		case (m)
			MODE_CHARGE: begin
				l.charge_relay = 1'b1;
				l.charge_led   = 1'b1;
			end
			MODE_PRE_RX: begin
				l.rx_relay = 1'b1;
			end
			MODE_RX: begin
				l.rx_relay    = 1'b1;
				l.uart_enable = 1'b1;
			end
			MODE_TURN: begin
				l.tx_relay = 1'b1;
			end
			MODE_TX, MODE_POST_TX: begin
				l.tx_relay    = 1'b1;
				l.uart_enable = 1'b1;
			end
			default: begin
				l = '0;
			end
		endcase
		return l;
	endfunction

endpackage

FILE: hw/rtl/charge_uart_time_slot_sequencer_core.sv
// ----------------------------------------------------------------------------
// charge_uart_time_slot_sequencer_core
// Mode sequencer for a shared charge / UART cable with host and cable queues.
// ----------------------------------------------------------------------------
// channel | dir | handshake         | payload
// s_*     | in  | s_tvalid/s_tready | one service pass
// m_*     | out | m_tvalid/m_tready | one or two results per pass, tlast on final
// apb     | in  | psel/penable      | seven 16-bit timeout registers at 4*i
//
// A pass is accepted every cycle while s_tready is high, then registered in
// the work and output stages. Results leave one per cycle while m_tready is
// high; a pass with an echo and a drained byte holds the input until both go.
// Output stall: one pass waits in the work stage, one in the output stage.
// Reset clears mode, timers and queue counts; no RAM clearing is needed.
// ----------------------------------------------------------------------------
module charge_uart_time_slot_sequencer_core #(
	parameter int TX_DEPTH = ctss_pkg::TX_DEPTH_DEF,
	parameter int RX_DEPTH = ctss_pkg::RX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// now_ms[31:0], host_valid[32], host_data[40:33], cable_valid[41],
	// cable_data[49:42], line_low[50], zero[55:51]
	input  logic [55:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// byte_out[7:0], mode[10:8], tx_relay[11], rx_relay[12],
	// charge_relay[13], charge_led[14], uart_enable[15]
	output logic [15:0] m_tdata,
	// kind[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);
	localparam int RX_CW = $clog2(RX_DEPTH + 1);

	// ---------------- configuration ----------------
	logic [15:0] charge_time_q, pre_rx_time_q, rx_time_q, turn_time_q;
	logic [15:0] tx_time_q, post_tx_time_q, recover_time_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_time_q  <= ctss_pkg::CHARGE_TIME_RST;
			pre_rx_time_q  <= ctss_pkg::PRE_RX_TIME_RST;
			rx_time_q      <= ctss_pkg::RX_TIME_RST;
			turn_time_q    <= ctss_pkg::TURN_TIME_RST;
			tx_time_q      <= ctss_pkg::TX_TIME_RST;
			post_tx_time_q <= ctss_pkg::POST_TX_TIME_RST;
			recover_time_q <= ctss_pkg::RECOVER_TIME_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				ctss_pkg::REG_CHARGE:  charge_time_q  <= pwdata[15:0];
				ctss_pkg::REG_PRE_RX:  pre_rx_time_q  <= pwdata[15:0];
				ctss_pkg::REG_RX:      rx_time_q      <= pwdata[15:0];
				ctss_pkg::REG_TURN:    turn_time_q    <= pwdata[15:0];
				ctss_pkg::REG_TX:      tx_time_q      <= pwdata[15:0];
				ctss_pkg::REG_POST_TX: post_tx_time_q <= pwdata[15:0];
				ctss_pkg::REG_RECOVER: recover_time_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			ctss_pkg::REG_CHARGE:  prdata = {16'd0, charge_time_q};
			ctss_pkg::REG_PRE_RX:  prdata = {16'd0, pre_rx_time_q};
			ctss_pkg::REG_RX:      prdata = {16'd0, rx_time_q};
			ctss_pkg::REG_TURN:    prdata = {16'd0, turn_time_q};
			ctss_pkg::REG_TX:      prdata = {16'd0, tx_time_q};
			ctss_pkg::REG_POST_TX: prdata = {16'd0, post_tx_time_q};
			ctss_pkg::REG_RECOVER: prdata = {16'd0, recover_time_q};
			default:               prdata = 32'd0;
		endcase
	end

	// ---------------- input fields ----------------
	logic [31:0] now_ms;
	logic        host_valid, cable_valid, line_low;
	logic [7:0]  host_data, cable_data;

	assign now_ms      = s_tdata[31:0];
	assign host_valid  = s_tdata[32];
	assign host_data   = s_tdata[40:33];
	assign cable_valid = s_tdata[41];
	assign cable_data  = s_tdata[49:42];
	assign line_low    = s_tdata[50];

	// ---------------- sequencer state ----------------
	ctss_pkg::mode_t mode_q, mode_d;
	logic [31:0]     start_q, wait_q, wait_d;
	logic            rx_rdy_q, rx_rdy_d, send_q, send_d;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q, tx_head_d, tx_tail_d, tx_rd_addr;
	logic [TX_CW-1:0] tx_cnt_q, tx_cnt_d;
	logic [RX_AW-1:0] rx_head_q, rx_tail_q, rx_head_d, rx_tail_d;
	logic [RX_CW-1:0] rx_cnt_q, rx_cnt_d;

	logic        in_acc;
	logic [31:0] elapsed;
	logic [32:0] rx_span;
	logic        mode_adv, pop_rx, pop_tx, push_rx, tx_byp;
	logic        tx_full, rx_full;
	logic [TX_AW-1:0] tx_head_p;
	logic [TX_CW-1:0] tx_cnt_p;

	assign elapsed = now_ms - start_q;
	assign rx_span = {1'b0, elapsed} + {1'b0, wait_q};
	assign tx_full = (tx_cnt_q == TX_CW'(TX_DEPTH));
	assign rx_full = (rx_cnt_q == RX_CW'(RX_DEPTH));

	function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
		return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		mode_d   = mode_q;
		mode_adv = 1'b0;
		wait_d   = wait_q;
		rx_rdy_d = rx_rdy_q;
		send_d   = send_q;
		pop_rx   = 1'b0;
		pop_tx   = 1'b0;
		push_rx  = 1'b0;

		// host push always lands first
		tx_head_p = tx_head_q;
		tx_cnt_p  = tx_cnt_q;
		tx_tail_d = tx_tail_q;
		if (host_valid) begin
			tx_tail_d = tx_inc(tx_tail_q);
			if (tx_full) begin
				tx_head_p = tx_inc(tx_head_q);
			end else begin
				tx_cnt_p = tx_cnt_q + 1'b1;
			end
		end

		case (mode_q)
			ctss_pkg::MODE_CHARGE: begin
				if (elapsed > {16'd0, charge_time_q}) begin
					mode_d   = ctss_pkg::MODE_PRE_RX;
					mode_adv = 1'b1;
				end else if (rx_rdy_q && rx_cnt_q != '0) begin
					pop_rx = 1'b1;
				end
			end
			ctss_pkg::MODE_PRE_RX: begin
				wait_d = elapsed;
				if (elapsed > {16'd0, pre_rx_time_q}) begin
					mode_d   = ctss_pkg::MODE_RECOVER;
					mode_adv = 1'b1;
				end else if (line_low) begin
					mode_d   = ctss_pkg::MODE_RX;
					mode_adv = 1'b1;
				end
			end
			ctss_pkg::MODE_RX: begin
				if (rx_span > {17'd0, rx_time_q}) begin
					mode_d   = ctss_pkg::MODE_TURN;
					mode_adv = 1'b1;
				end else if (cable_valid && cable_data != ctss_pkg::NULL_BYTE) begin
					push_rx = 1'b1;
					if (rx_cnt_q + 1'b1 < RX_CW'(RX_DEPTH) && !rx_full) begin
						rx_rdy_d = 1'b1;
					end
				end
			end
			ctss_pkg::MODE_TURN: begin
				if (elapsed > {16'd0, turn_time_q}) begin
					mode_d   = ctss_pkg::MODE_TX;
					mode_adv = 1'b1;
					send_d   = 1'b1;
				end
			end
			ctss_pkg::MODE_TX: begin
				if (elapsed > {16'd0, tx_time_q}) begin
					mode_d   = ctss_pkg::MODE_POST_TX;
					mode_adv = 1'b1;
				end else if (send_q) begin
					if (tx_cnt_p != '0) begin
						pop_tx = 1'b1;
					end
					if (tx_cnt_p <= TX_CW'(1)) begin
						send_d = 1'b0;
					end
				end
			end
			ctss_pkg::MODE_POST_TX: begin
				if (elapsed > {16'd0, post_tx_time_q}) begin
					mode_d   = ctss_pkg::MODE_CHARGE;
					mode_adv = 1'b1;
				end
			end
			ctss_pkg::MODE_RECOVER: begin
				if (elapsed > {16'd0, recover_time_q}) begin
					mode_d   = ctss_pkg::MODE_CHARGE;
					mode_adv = 1'b1;
				end
			end
			default: ;
		endcase

		tx_head_d  = pop_tx ? tx_inc(tx_head_p) : tx_head_p;
		tx_cnt_d   = pop_tx ? tx_cnt_p - 1'b1 : tx_cnt_p;
		tx_rd_addr = tx_head_p;
		// pop of the byte pushed in this same pass, RAM has not seen it yet
		tx_byp     = pop_tx & host_valid & (tx_cnt_q == '0);

		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		rx_cnt_d  = rx_cnt_q;
		if (push_rx) begin
			rx_tail_d = rx_inc(rx_tail_q);
			if (rx_full) begin
				rx_head_d = rx_inc(rx_head_q);
			end else begin
				rx_cnt_d = rx_cnt_q + 1'b1;
			end
		end
		if (pop_rx) begin
			rx_head_d = rx_inc(rx_head_q);
			rx_cnt_d  = rx_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ctss_pkg::MODE_CHARGE;
			start_q   <= '0;
			wait_q    <= '0;
			rx_rdy_q  <= 1'b0;
			send_q    <= 1'b0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			tx_cnt_q  <= '0;
			rx_head_q <= '0;
			rx_tail_q <= '0;
			rx_cnt_q  <= '0;
		end else if (in_acc) begin
			mode_q    <= mode_d;
			if (mode_adv) begin
				start_q <= now_ms;
			end
			wait_q    <= wait_d;
			rx_rdy_q  <= rx_rdy_d;
			send_q    <= send_d;
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			tx_cnt_q  <= tx_cnt_d;
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			rx_cnt_q  <= rx_cnt_d;
		end
	end

	// ---------------- queue memories ----------------
	logic [7:0] tx_rdata, rx_rdata;

	ctss_ram #(
		.WIDTH (8),
		.DEPTH (TX_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (in_acc & host_valid),
		.waddr (tx_tail_q),
		.wdata (host_data),
		.re    (in_acc & pop_tx),
		.raddr (tx_rd_addr),
		.rdata (tx_rdata)
	);

	ctss_ram #(
		.WIDTH (8),
		.DEPTH (RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (in_acc & push_rx),
		.waddr (rx_tail_q),
		.wdata (cable_data),
		.re    (in_acc & pop_rx),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

	// ---------------- work stage ----------------
	logic            valid_s1;
	logic            host_s1, drain_s1, src_tx_s1, byp_s1;
	logic [7:0]      hbyte_s1;
	ctss_pkg::mode_t mode_s1;
	logic [7:0]      dbyte;
	ctss_pkg::kind_t dkind;

	// ---------------- output stage ----------------
	logic            out_vq, two_q, idx_q;
	ctss_pkg::kind_t k0_q, k1_q;
	logic [7:0]      b0_q, b1_q;
	ctss_pkg::mode_t omode_q;
	ctss_pkg::levels_t lv;
	logic            out_fire, out_done, out_free, s1_move;

	assign out_fire = out_vq & m_tready;
	assign out_done = out_fire & (idx_q | ~two_q);
	assign out_free = ~out_vq | out_done;
	assign s1_move  = valid_s1 & out_free;
	assign s_tready = ~valid_s1 | out_free;
	assign in_acc   = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			host_s1   <= host_valid;
			hbyte_s1  <= host_data;
			drain_s1  <= pop_tx | pop_rx;
			src_tx_s1 <= pop_tx;
			byp_s1    <= tx_byp;
			mode_s1   <= mode_d;
		end
	end

	assign dbyte = byp_s1 ? hbyte_s1 : (src_tx_s1 ? tx_rdata : rx_rdata);
	assign dkind = src_tx_s1 ? ctss_pkg::KIND_CABLE : ctss_pkg::KIND_HOST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vq <= 1'b0;
			idx_q  <= 1'b0;
		end else if (s1_move) begin
			out_vq <= 1'b1;
			idx_q  <= 1'b0;
		end else if (out_done) begin
			out_vq <= 1'b0;
		end else if (out_fire) begin
			idx_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			two_q   <= host_s1 & drain_s1;
			omode_q <= mode_s1;
			k1_q    <= dkind;
			b1_q    <= dbyte;
			if (host_s1) begin
				k0_q <= ctss_pkg::KIND_HOST;
				b0_q <= hbyte_s1;
			end else if (drain_s1) begin
				k0_q <= dkind;
				b0_q <= dbyte;
			end else begin
				k0_q <= ctss_pkg::KIND_STATUS;
				b0_q <= '0;
			end
		end
	end

	assign lv       = ctss_pkg::mode_levels(omode_q);
	assign m_tvalid = out_vq;
	assign m_tlast  = idx_q | ~two_q;
	assign m_tuser  = idx_q ? k1_q : k0_q;
	assign m_tdata  = {lv.uart_enable, lv.charge_led, lv.charge_relay, lv.rx_relay,
		lv.tx_relay, omode_q, (idx_q ? b1_q : b0_q)};

endmodule

FILE: hw/rtl/ctss_ram.sv
// ----------------------------------------------------------------------------
// ctss_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ctss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
